// ===== hdl/emv_pkg.sv =====
// Shared constants, types and the control store of the multiturn angle and velocity block.
package emv_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int TIMER_BITS = 24;
  localparam int TURN_BITS  = 16;
  localparam int POS_BITS   = TURN_BITS + ANGLE_BITS;
  localparam int FDIV_BITS  = 16;
  localparam int VEL_BITS   = 32;
  localparam int PROD_BITS  = POS_BITS + TIMER_BITS;
  localparam int DIV_STEPS  = PROD_BITS / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_W      = TIMER_BITS;
  localparam int IDX_W      = 2;
  localparam int PC_W       = 3;

  localparam int IN_FIELDS  = ANGLE_BITS + TIMER_BITS;
  localparam int IN_DATA_W  = ((IN_FIELDS + 7) / 8) * 8;
  localparam int OUT_FIELDS = POS_BITS + TURN_BITS + VEL_BITS;
  localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

  localparam logic [ANGLE_BITS-1:0] THR_RESET  = ANGLE_BITS'(3276);
  localparam logic [TIMER_BITS-1:0] TPS_RESET  = TIMER_BITS'(9000000);
  localparam logic [TIMER_BITS-1:0] MIN_RESET  = TIMER_BITS'(900);
  localparam logic [FDIV_BITS-1:0]  FDIV_RESET = FDIV_BITS'(10000);

  typedef enum logic [IDX_W-1:0] {
    REG_WRAP_THRESHOLD     = 2'd0,
    REG_TICKS_PER_SECOND   = 2'd1,
    REG_MIN_INTERVAL_TICKS = 2'd2,
    REG_FALLBACK_DIVISOR   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    UOP_LOAD,
    UOP_UNWRAP,
    UOP_DELTA,
    UOP_MUL,
    UOP_DIVSET,
    UOP_DIV,
    UOP_NOP,
    UOP_WB
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DIV_MORE,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    uop_t             uop;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctl_t;

  typedef struct packed {
    logic div_more;
    logic out_full;
  } stat_t;

  function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_t w;
    unique case (pc)
      3'd0:    w = '{uop: UOP_LOAD,   cond: COND_NO_INPUT, target: 3'd0};
      3'd1:    w = '{uop: UOP_UNWRAP, cond: COND_NEVER,    target: 3'd0};
      3'd2:    w = '{uop: UOP_DELTA,  cond: COND_NEVER,    target: 3'd0};
      3'd3:    w = '{uop: UOP_MUL,    cond: COND_NEVER,    target: 3'd0};
      3'd4:    w = '{uop: UOP_DIVSET, cond: COND_NEVER,    target: 3'd0};
      3'd5:    w = '{uop: UOP_DIV,    cond: COND_DIV_MORE, target: 3'd5};
      3'd6:    w = '{uop: UOP_NOP,    cond: COND_OUT_FULL, target: 3'd6};
      3'd7:    w = '{uop: UOP_WB,     cond: COND_ALWAYS,   target: 3'd0};
      default: w = '{uop: UOP_NOP,    cond: COND_ALWAYS,   target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/encoder_multiturn_velocity.sv =====
// Top level of the multiturn angle unwrap and velocity block.
// Each item carries a single-turn angle reading and a down-counting timer stamp; the block
// returns one result item per input item with the multiturn position, the wrapping turn
// count, the velocity in counts per second (the change over the fallback divisor on a
// short interval) and a flag for a short interval. The next item is accepted only after an
// item's write-back; the two-bits-per-cycle divider forms the velocity quotient. A finished
// result waits in the output register while the next item is accepted and worked on,
// holding before its write-back while that register is full. Configuration registers are
// written through the cfg port with no wait and take effect at the next step reading them.
module encoder_multiturn_velocity
  import emv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // raw_angle, timestamp
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // position, turns, velocity
  output logic                  out_tuser   // short_interval
);

  ctl_t                  ctl;
  stat_t                 stat;
  logic [POS_BITS-1:0]   position;
  logic [TURN_BITS-1:0]  turns;
  logic [VEL_BITS-1:0]   velocity;

  emv_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .ctl       (ctl)
  );

  emv_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .raw_angle      (in_tdata[ANGLE_BITS-1:0]),
    .timestamp      (in_tdata[ANGLE_BITS +: TIMER_BITS]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .position       (position),
    .turns          (turns),
    .velocity       (velocity),
    .short_interval (out_tuser)
  );

  assign in_tready = (ctl.uop == UOP_LOAD);
  assign out_tdata = {{(OUT_DATA_W - OUT_FIELDS){1'b0}}, velocity, turns, position};

endmodule

// ===== hdl/emv_seq.sv =====
// Step counter and control store walk with conditional jumps.
module emv_seq
  import emv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  stat_t stat,
  output ctl_t  ctl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    ctl = ucode_rom(pc_r);
    unique case (ctl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !in_tvalid;
      COND_DIV_MORE: take = stat.div_more;
      COND_OUT_FULL: take = stat.out_full;
      default:       take = 1'b0;
    endcase
    pc_nxt = take ? ctl.target : pc_r + PC_W'(1);
  end

endmodule

// ===== hdl/emv_dp.sv =====
// Datapath: configuration, unwrap state, multiplier, radix-4 divider and result register.
module emv_dp
  import emv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl,
  output stat_t                 stat,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [ANGLE_BITS-1:0] raw_angle,
  input  logic [TIMER_BITS-1:0] timestamp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_BITS-1:0]   position,
  output logic [TURN_BITS-1:0]  turns,
  output logic [VEL_BITS-1:0]   velocity,
  output logic                  short_interval
);

  logic [ANGLE_BITS-1:0] thr_r;
  logic [TIMER_BITS-1:0] tps_r;
  logic [TIMER_BITS-1:0] min_r;
  logic [FDIV_BITS-1:0]  fdiv_r;

  logic [ANGLE_BITS-1:0] last_reading_r, last_reading_nxt;
  logic [TURN_BITS-1:0]  turn_r, turn_nxt;
  logic [POS_BITS-1:0]   last_pos_r;
  logic [TIMER_BITS-1:0] last_stamp_r;
  logic                  out_valid_r;

  logic [ANGLE_BITS-1:0] raw_r;
  logic [TIMER_BITS-1:0] ts_r;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [POS_BITS-1:0]   mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  short_r, short_nxt;
  logic [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic [PROD_BITS-1:0]  quo_r, quo_nxt;
  logic [TIMER_BITS-1:0] rem_r, rem_nxt;
  logic [TIMER_BITS-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]      cnt_r;

  logic [POS_BITS-1:0]   out_pos_r;
  logic [TURN_BITS-1:0]  out_turns_r;
  logic [VEL_BITS-1:0]   out_vel_r, vel_nxt;
  logic                  out_short_r;

  logic [ANGLE_BITS:0]   fwd, back, jmag;
  logic                  crossing;
  logic [POS_BITS-1:0]   dfw, dbk;
  logic [FDIV_BITS-1:0]  fdiv_eff;
  logic                  hi_nz, sat;

  // Turn boundary detection and elapsed ticks of the down-counter.
  always_comb begin
    fwd      = {1'b0, raw_r} - {1'b0, last_reading_r};
    back     = {1'b0, last_reading_r} - {1'b0, raw_r};
    jmag     = fwd[ANGLE_BITS] ? back : fwd;
    crossing = jmag > {1'b0, thr_r};
    if (!crossing) begin
      turn_nxt = turn_r;
    end else if (!fwd[ANGLE_BITS]) begin
      turn_nxt = turn_r - TURN_BITS'(1);
    end else begin
      turn_nxt = turn_r + TURN_BITS'(1);
    end
    last_reading_nxt = raw_r;
    elapsed_nxt = last_stamp_r + ~ts_r + TIMER_BITS'(ts_r < last_stamp_r);
  end

  // Position change as sign and magnitude, both differences in parallel.
  always_comb begin
    pos_nxt   = {turn_r, raw_r};
    dfw       = pos_nxt - last_pos_r;
    dbk       = last_pos_r - pos_nxt;
    neg_nxt   = dfw[POS_BITS-1];
    mag_nxt   = neg_nxt ? dbk : dfw;
    short_nxt = (elapsed_r < min_r) || (elapsed_r == '0);
  end

  assign prod_nxt = mag_r * tps_r;
  assign fdiv_eff = (fdiv_r == '0) ? FDIV_BITS'(1) : fdiv_r;

  // Two restoring division steps per cycle.
  always_comb begin
    logic [TIMER_BITS:0]  t;
    logic [TIMER_BITS-1:0] r;
    logic [PROD_BITS-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[PROD_BITS-1]};
      q = {q[PROD_BITS-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t    = t - {1'b0, den_r};
        q[0] = 1'b1;
      end
      r = t[TIMER_BITS-1:0];
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  assign den_nxt = short_r ? TIMER_BITS'(fdiv_eff) : elapsed_r;

  // Saturation of the quotient magnitude to the signed result range.
  always_comb begin
    hi_nz = |quo_r[PROD_BITS-1:VEL_BITS];
    if (neg_r) begin
      sat     = hi_nz || (quo_r[VEL_BITS-1] && (|quo_r[VEL_BITS-2:0]));
      vel_nxt = sat ? {1'b1, {(VEL_BITS-1){1'b0}}} : ('0 - quo_r[VEL_BITS-1:0]);
    end else begin
      sat     = hi_nz || quo_r[VEL_BITS-1];
      vel_nxt = sat ? {1'b0, {(VEL_BITS-1){1'b1}}} : quo_r[VEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r          <= THR_RESET;
      tps_r          <= TPS_RESET;
      min_r          <= MIN_RESET;
      fdiv_r         <= FDIV_RESET;
      last_reading_r <= '0;
      turn_r         <= '0;
      last_pos_r     <= '0;
      last_stamp_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_WRAP_THRESHOLD:     thr_r  <= cfg_wdata[ANGLE_BITS-1:0];
          REG_TICKS_PER_SECOND:   tps_r  <= cfg_wdata[TIMER_BITS-1:0];
          REG_MIN_INTERVAL_TICKS: min_r  <= cfg_wdata[TIMER_BITS-1:0];
          REG_FALLBACK_DIVISOR:   fdiv_r <= cfg_wdata[FDIV_BITS-1:0];
          default: ;
        endcase
      end
      if (ctl.uop == UOP_UNWRAP) begin
        turn_r         <= turn_nxt;
        last_reading_r <= last_reading_nxt;
      end
      if (ctl.uop == UOP_WB) begin
        last_pos_r   <= pos_r;
        last_stamp_r <= ts_r;
        out_valid_r  <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.uop)
      UOP_LOAD: begin
        raw_r <= raw_angle;
        ts_r  <= timestamp;
      end
      UOP_UNWRAP: begin
        elapsed_r <= elapsed_nxt;
      end
      UOP_DELTA: begin
        pos_r   <= pos_nxt;
        neg_r   <= neg_nxt;
        mag_r   <= mag_nxt;
        short_r <= short_nxt;
      end
      UOP_MUL: begin
        prod_r <= prod_nxt;
      end
      UOP_DIVSET: begin
        quo_r <= short_r ? PROD_BITS'(mag_r) : prod_r;
        rem_r <= '0;
        den_r <= den_nxt;
        cnt_r <= CNT_W'(DIV_STEPS - 1);
      end
      UOP_DIV: begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      UOP_WB: begin
        out_pos_r   <= pos_r;
        out_turns_r <= turn_r;
        out_vel_r   <= vel_nxt;
        out_short_r <= short_r;
      end
      default: ;
    endcase
  end

  assign stat.div_more  = (cnt_r != '0);
  assign stat.out_full  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign position       = out_pos_r;
  assign turns          = out_turns_r;
  assign velocity       = out_vel_r;
  assign short_interval = out_short_r;

endmodule
